// ===== hw/rtl/dpe_pkg.sv =====
package dpe_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int LOG_ITERS     = 16;
  localparam int NUM_AXES      = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [31:0] INV_MASS_RST = 32'd65536;
  localparam logic [16:0] DAMPING_RST  = 17'd64881;
  localparam logic [16:0] ONE_Q16      = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_MASS = 3'd0,
    CFG_DAMPING  = 3'd1,
    CFG_ACCEL_X  = 3'd2,
    CFG_ACCEL_Y  = 3'd3,
    CFG_ACCEL_Z  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REQ_FORCE = 2'd0,
    REQ_INTEG = 2'd1,
    REQ_SETP  = 2'd2,
    REQ_SETV  = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [15:0]        step_time;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               bad_step;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_LOGI,
    OP_SQ,
    OP_LMUL,
    OP_EXP,
    OP_FIN,
    OP_POS,
    OP_FM,
    OP_ACC,
    OP_DAMP
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_LOGI,
    ST_SQ,
    ST_LMUL,
    ST_EXP,
    ST_FIN,
    ST_POS,
    ST_FM,
    ST_ACC,
    ST_DAMP,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    op_t        op;
    logic       wb;
    logic [3:0] iter;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic integ;
    logic dt_zero;
  } stat_t;

  // 2^(2^-k) in Q2.30
  localparam logic [31:0] EXP2_TAB [LOG_ITERS] = '{
    32'd1518500250, 32'd1276901416, 32'd1170923762, 32'd1121280436,
    32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
    32'd1075196443, 32'd1074468887, 32'd1074105294, 32'd1073923544,
    32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181
  };

endpackage

// ===== hw/rtl/dpe_ctrl.sv =====
module dpe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           result_stall,
  input  dpe_pkg::stat_t stat,
  output dpe_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           result_valid
);
  import dpe_pkg::*;

  ctl_state_t state, state_next;
  logic       phase, phase_next;
  logic [3:0] iter, iter_next;
  logic [1:0] axis, axis_next;
  logic       last_iter;

  assign last_iter = (iter == 4'(LOG_ITERS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 1'b0;
      iter  <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      iter  <= iter_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next   = state;
    phase_next   = 1'b0;
    iter_next    = iter;
    axis_next    = axis;
    cmd.op       = OP_NONE;
    cmd.wb       = phase;
    cmd.iter     = iter;
    cmd.axis     = axis;
    busy         = 1'b1;
    result_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          cmd.op     = OP_CAPTURE;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        iter_next = '0;
        axis_next = '0;
        if (!stat.integ) state_next = ST_LOAD;
        else if (stat.dt_zero) state_next = ST_OUT;
        else state_next = ST_LOGI;
      end
      ST_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = ST_OUT;
      end
      ST_LOGI: begin
        cmd.op     = OP_LOGI;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.op     = OP_SQ;
        phase_next = ~phase;
        if (phase) begin
          if (last_iter) begin
            iter_next  = '0;
            state_next = ST_LMUL;
          end else begin
            iter_next = iter + 4'd1;
          end
        end
      end
      ST_LMUL: begin
        cmd.op     = OP_LMUL;
        phase_next = ~phase;
        if (phase) state_next = ST_EXP;
      end
      ST_EXP: begin
        cmd.op     = OP_EXP;
        phase_next = ~phase;
        if (phase) begin
          if (last_iter) begin
            iter_next  = '0;
            state_next = ST_FIN;
          end else begin
            iter_next = iter + 4'd1;
          end
        end
      end
      ST_FIN: begin
        cmd.op     = OP_FIN;
        state_next = ST_POS;
      end
      ST_POS: begin
        cmd.op     = OP_POS;
        phase_next = ~phase;
        if (phase) state_next = ST_FM;
      end
      ST_FM: begin
        cmd.op     = OP_FM;
        phase_next = ~phase;
        if (phase) state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.op     = OP_ACC;
        phase_next = ~phase;
        if (phase) state_next = ST_DAMP;
      end
      ST_DAMP: begin
        cmd.op     = OP_DAMP;
        phase_next = ~phase;
        if (phase) begin
          if (axis == 2'(NUM_AXES - 1)) begin
            state_next = ST_OUT;
          end else begin
            axis_next  = axis + 2'd1;
            state_next = ST_POS;
          end
        end
      end
      ST_OUT: begin
        result_valid = 1'b1;
        if (!result_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/dpe_datapath.sv =====
module dpe_datapath #(
  parameter int FRAC_BITS = dpe_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dpe_pkg::cmd_t                   cmd,
  input  dpe_pkg::req_t                   item,
  input  logic                            cfg_we,
  input  logic [dpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpe_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dpe_pkg::stat_t                  stat,
  output dpe_pkg::rsp_t                   result
);
  import dpe_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [67:0] rnd16(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = v + 68'sd32768;
    return t >>> 16;
  endfunction

  // configuration
  logic [31:0]        inv_mass;
  logic [16:0]        damping;
  logic signed [31:0] accel [NUM_AXES];

  // particle state
  logic signed [31:0] pos       [NUM_AXES];
  logic signed [31:0] vel       [NUM_AXES];
  logic signed [31:0] force_sum [NUM_AXES];

  // work registers
  req_t               req;
  logic               bad;
  logic signed [67:0] prod;
  logic [30:0]        x;
  logic signed [21:0] logv;
  logic signed [5:0]  n;
  logic [15:0]        g;
  logic [31:0]        p;
  logic [16:0]        f;
  logic signed [31:0] acc;
  logic signed [31:0] nv;

  logic signed [33:0] mul_a, mul_b;
  logic signed [31:0] rv [NUM_AXES];
  logic [3:0]         lead;
  logic [31:0]        sq;
  logic [32:0]        exp_sum;
  logic [4:0]         sh;
  logic [32:0]        f_raw;
  logic signed [67:0] fm;
  logic signed [67:0] fm_rnd;
  logic [1:0]         ax;

  assign ax = cmd.axis;
  assign rv[0] = req.vec_x;
  assign rv[1] = req.vec_y;
  assign rv[2] = req.vec_z;
  assign fm_rnd = 68'sd1 <<< (FRAC_BITS - 1);

  assign stat.integ   = (req.req_type == REQ_INTEG);
  assign stat.dt_zero = (req.step_time == 16'd0);

  always_comb begin
    lead = '0;
    for (int i = 0; i < 16; i++) begin
      if (damping[i]) lead = 4'(i);
    end
  end

  assign sq      = prod[61:30];
  assign exp_sum = prod[62:30] + 33'(prod[29]);
  assign sh      = 5'(6'sd14 - n);
  assign f_raw   = (33'(p) + (33'd1 << (sh - 5'd1))) >> sh;
  assign fm      = (prod + fm_rnd) >>> FRAC_BITS;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ: begin
        mul_a = {3'b0, x};
        mul_b = {3'b0, x};
      end
      OP_LMUL: begin
        mul_a = 34'(logv);
        mul_b = {18'b0, req.step_time};
      end
      OP_EXP: begin
        mul_a = {2'b0, p};
        mul_b = {2'b0, EXP2_TAB[cmd.iter]};
      end
      OP_POS: begin
        mul_a = 34'(vel[ax]);
        mul_b = {18'b0, req.step_time};
      end
      OP_FM: begin
        mul_a = 34'(force_sum[ax]);
        mul_b = {2'b0, inv_mass};
      end
      OP_ACC: begin
        mul_a = 34'(acc);
        mul_b = {18'b0, req.step_time};
      end
      OP_DAMP: begin
        mul_a = 34'(nv);
        mul_b = {17'b0, f};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mass <= INV_MASS_RST;
      damping  <= DAMPING_RST;
      for (int i = 0; i < NUM_AXES; i++) begin
        accel[i]     <= '0;
        pos[i]       <= '0;
        vel[i]       <= '0;
        force_sum[i] <= '0;
      end
      bad <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INV_MASS: inv_mass <= cfg_data;
          CFG_DAMPING:  damping  <= cfg_data[16:0];
          CFG_ACCEL_X:  accel[0] <= cfg_data;
          CFG_ACCEL_Y:  accel[1] <= cfg_data;
          CFG_ACCEL_Z:  accel[2] <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.op)
        OP_CAPTURE: begin
          req <= item;
          bad <= (item.req_type == REQ_INTEG) && (item.step_time == 16'd0);
        end
        OP_LOAD: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            unique case (req.req_type)
              REQ_FORCE: force_sum[i] <= sat32(68'(force_sum[i]) + 68'(rv[i]));
              REQ_SETP:  pos[i]       <= rv[i];
              REQ_SETV:  vel[i]       <= rv[i];
              default: ;
            endcase
          end
        end
        OP_LOGI: begin
          x    <= 31'({15'b0, damping[15:0]} << (5'd30 - 5'(lead)));
          // integer part lead - 16 is always negative
          logv <= {2'b11, lead, 16'd0};
        end
        OP_SQ: begin
          if (cmd.wb) begin
            // renormalize into [1,2) and take one bit of the log fraction
            if (sq[31]) begin
              x    <= sq[31:1];
              logv <= logv + (22'sd1 <<< (4'd15 - cmd.iter));
            end else begin
              x <= sq[30:0];
            end
          end
        end
        OP_LMUL: begin
          if (cmd.wb) begin
            n <= prod[37:32];
            g <= prod[31:16];
            p <= 32'd1 << 30;
          end
        end
        OP_EXP: begin
          if (cmd.wb && g[4'd15 - cmd.iter]) p <= exp_sum[31:0];
        end
        OP_FIN: begin
          if (damping == 17'd0) f <= '0;
          else if (damping[16]) f <= ONE_Q16;
          else f <= f_raw[16:0];
        end
        OP_POS: begin
          if (cmd.wb) pos[ax] <= sat32(68'(pos[ax]) + rnd16(prod));
        end
        OP_FM: begin
          if (cmd.wb) acc <= sat32(68'(accel[ax]) + fm);
        end
        OP_ACC: begin
          if (cmd.wb) nv <= sat32(68'(vel[ax]) + rnd16(prod));
        end
        OP_DAMP: begin
          if (cmd.wb) begin
            vel[ax]       <= sat32(rnd16(prod));
            force_sum[ax] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign result.pos_x    = pos[0];
  assign result.pos_y    = pos[1];
  assign result.pos_z    = pos[2];
  assign result.vel_x    = vel[0];
  assign result.vel_y    = vel[1];
  assign result.vel_z    = vel[2];
  assign result.bad_step = bad;

endmodule

// ===== hw/rtl/damped_particle_euler_step.sv =====
// Damped point-particle integrator. One word in gives one word out with the
// position and velocity after it. An add-force or set item passes through
// the dispatch and load states to a valid result; an integrate item with a
// zero step goes from dispatch straight to the result and returns bad_step.
// The integrate time is set by one shared 34x34 multiplier, registered: 16
// squarings for log2 of damping, one product by the step, 16 table products
// for exp2, then four products per axis. One item is in flight at a time; the
// user writes configuration only while idle; the block does not enforce it.
module damped_particle_euler_step #(
  parameter int FRAC_BITS = dpe_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  dpe_pkg::req_t                   item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output dpe_pkg::rsp_t                   result,
  input  logic                            cfg_we,
  input  logic [dpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dpe_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy;
  logic  accept;

  assign item_stall = busy;
  assign accept     = item_valid && !busy;

  dpe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  dpe_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .result    (result)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("word accepted while a result is pending");

  a_capture_on_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_CAPTURE) |-> (item_valid && !item_stall))
    else $error("capture without an accepted word");

  a_bad_only_zero_step: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.bad_step) |-> (stat.integ && stat.dt_zero))
    else $error("bad_step flagged for a valid request");

endmodule

// ===== tb/sv/damped_particle_euler_step_tb.sv =====
`timescale 1ns / 100ps

module damped_particle_euler_step_tb;
  import dpe_pkg::*;

  localparam int IDLE_TAIL = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  req_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  rsp_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  damped_particle_euler_step u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // particle state mirror
  logic [31:0] inv_mass_q;
  logic [16:0] damping_q;
  logic signed [31:0] accel_q [3];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] force_q [3];

  localparam logic [31:0] EXP2_Q30 [16] = '{
    32'd1518500250, 32'd1276901416, 32'd1170923762, 32'd1121280436,
    32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
    32'd1075196443, 32'd1074468887, 32'd1074105294, 32'd1073923544,
    32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181
  };

  rsp_t pending_rsp [$];
  int errors = 0;
  int n_items = 0, n_results = 0, n_bad = 0, n_integ = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_recv = 1'b0;

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // arithmetic shift = floor; add half first for round half up
  function automatic logic signed [127:0] rnd_shr(input logic signed [127:0] v, input int s);
    return (v + (128'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] damp_pow(input logic [16:0] d, input logic [15:0] dt);
    int m, i;
    logic [63:0] x;
    logic signed [63:0] lg, z, n, g;
    logic [63:0] p;
    int sh;
    if (d == 0) return 0;
    if (d >= ONE_Q16) return 32'd65536;
    m = 0;
    while (m < 15 && (d >> (m + 1)) != 0) m++;
    x = 64'(d) << (30 - m);
    lg = 64'(m - 16) * 65536;
    for (i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        lg += 64'sd1 <<< (15 - i);
      end
    end
    z = (lg * $signed({48'd0, dt})) >>> 16;
    n = z >>> 16;
    g = z - n * 65536;
    p = 64'd1 << 30;
    for (i = 0; i < 16; i++) begin
      if (g[15 - i]) p = (p * EXP2_Q30[i] + (64'd1 << 29)) >> 30;
    end
    sh = int'(-n) + 14;
    return 32'((p + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic rsp_t particle_update(input req_t r);
    rsp_t o;
    logic [31:0] f;
    logic signed [31:0] v [3];
    logic signed [127:0] fm, acc, nv;
    v[0] = r.vec_x; v[1] = r.vec_y; v[2] = r.vec_z;
    o = '0;
    case (req_kind_t'(r.req_type))
      REQ_FORCE: for (int i = 0; i < 3; i++) force_q[i] = clamp32(128'(force_q[i]) + v[i]);
      REQ_SETP: for (int i = 0; i < 3; i++) pos_q[i] = v[i];
      REQ_SETV: for (int i = 0; i < 3; i++) vel_q[i] = v[i];
      default: begin
        if (r.step_time == 0) begin
          o.bad_step = 1'b1;
        end else begin
          f = damp_pow(damping_q, r.step_time);
          for (int i = 0; i < 3; i++) begin
            pos_q[i] = clamp32(128'(pos_q[i]) +
                               rnd_shr(128'(vel_q[i]) * $signed({1'b0, r.step_time}), 16));
            fm = rnd_shr(128'(force_q[i]) * $signed({1'b0, inv_mass_q}), 16);
            acc = clamp32(128'(accel_q[i]) + fm);
            nv = clamp32(128'(vel_q[i]) + rnd_shr(acc * $signed({1'b0, r.step_time}), 16));
            vel_q[i] = clamp32(rnd_shr(nv * $signed({1'b0, f}), 16));
            force_q[i] = 0;
          end
        end
      end
    endcase
    o.pos_x = pos_q[0]; o.pos_y = pos_q[1]; o.pos_z = pos_q[2];
    o.vel_x = vel_q[0]; o.vel_y = vel_q[1]; o.vel_z = vel_q[2];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got %h want %h", n_results, what, got, want);
  endtask

  // receive and compare
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        rsp_t w;
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected result word", '0, '0);
        end else begin
          w = pending_rsp.pop_front();
          if (result.pos_x !== w.pos_x) report_mismatch("pos_x", result.pos_x, w.pos_x);
          if (result.pos_y !== w.pos_y) report_mismatch("pos_y", result.pos_y, w.pos_y);
          if (result.pos_z !== w.pos_z) report_mismatch("pos_z", result.pos_z, w.pos_z);
          if (result.vel_x !== w.vel_x) report_mismatch("vel_x", result.vel_x, w.vel_x);
          if (result.vel_y !== w.vel_y) report_mismatch("vel_y", result.vel_y, w.vel_y);
          if (result.vel_z !== w.vel_z) report_mismatch("vel_z", result.vel_z, w.vel_z);
          if (result.bad_step !== w.bad_step)
            report_mismatch("bad_step", 32'(result.bad_step), 32'(w.bad_step));
        end
        n_results++;
      end
      if (hold_recv) result_stall <= 1'b1;
      else result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INV_MASS: inv_mass_q = val;
      CFG_DAMPING: damping_q = val[16:0];
      CFG_ACCEL_X: accel_q[0] = val;
      CFG_ACCEL_Y: accel_q[1] = val;
      default: accel_q[2] = val;
    endcase
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // offer one word, hold until taken; optionally check a typed-in result
  task automatic send_item(input req_t r, input bit has_want, input rsp_t want);
    rsp_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    item <= r;
    do @(posedge clk); while (item_stall);
    p = particle_update(r);
    if (has_want && p !== want)
      report_mismatch("directed row predictor", 32'(n_items), '0);
    pending_rsp.push_back(p);
    n_items++;
    if (r.req_type == REQ_INTEG) begin
      n_integ++;
      if (r.step_time == 0) n_bad++;
    end
  endtask

  function automatic logic [31:0] rand_vec();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(131072) - 65536;
      3: return 32'($signed($urandom_range(4194304)) - 2097152);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.req_type = 2'($urandom_range(3));
    if ($urandom_range(3) == 0) r.req_type = REQ_INTEG;
    r.vec_x = rand_vec(); r.vec_y = rand_vec(); r.vec_z = rand_vec();
    case ($urandom_range(7))
      0: r.step_time = 16'd0;
      1: r.step_time = 16'hffff;
      2: r.step_time = 16'($urandom_range(1, 64));
      default: r.step_time = 16'($urandom);
    endcase
    return r;
  endfunction

  typedef struct {
    req_t r;
    bit has_want;
    rsp_t want;
  } row_t;

  function automatic rsp_t mk_rsp(input logic [31:0] p, input logic [31:0] v,
                                  input logic b);
    rsp_t o;
    o.pos_x = p; o.pos_y = p; o.pos_z = p;
    o.vel_x = v; o.vel_y = v; o.vel_z = v;
    o.bad_step = b;
    return o;
  endfunction

  function automatic req_t mk_req(input req_kind_t k, input logic [31:0] v,
                                  input logic [15:0] dt);
    req_t r;
    r.req_type = k; r.vec_x = v; r.vec_y = v; r.vec_z = v; r.step_time = dt;
    return r;
  endfunction

  initial begin
    row_t rows [$];
    req_t r;
    logic [31:0] dsets [4];
    logic [31:0] msets [4];
    inv_mass_q = INV_MASS_RST;
    damping_q = DAMPING_RST;
    for (int i = 0; i < 3; i++) begin
      accel_q[i] = 0; pos_q[i] = 0; vel_q[i] = 0; force_q[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    rows.push_back('{mk_req(REQ_INTEG, 32'h0, 16'h0), 1, mk_rsp(0, 0, 1)});
    rows.push_back('{mk_req(REQ_INTEG, 32'h0, 16'h1), 1, mk_rsp(0, 0, 0)});
    rows.push_back('{mk_req(REQ_SETP, 32'h7fffffff, 0), 1, mk_rsp(32'h7fffffff, 0, 0)});
    rows.push_back('{mk_req(REQ_SETV, 32'h7fffffff, 16'hffff), 1,
                     mk_rsp(32'h7fffffff, 32'h7fffffff, 0)});
    rows.push_back('{mk_req(REQ_INTEG, 32'h0, 16'hffff), 0, '0});
    rows.push_back('{mk_req(REQ_INTEG, 32'h5a5a5a5a, 16'h0), 0, '0});
    rows.push_back('{mk_req(REQ_SETP, 32'h80000000, 0), 0, '0});
    rows.push_back('{mk_req(REQ_SETV, 32'h80000000, 0), 0, '0});
    rows.push_back('{mk_req(REQ_FORCE, 32'h80000000, 0), 0, '0});
    rows.push_back('{mk_req(REQ_FORCE, 32'h80000000, 0), 0, '0});
    rows.push_back('{mk_req(REQ_INTEG, 32'h0, 16'hffff), 0, '0});
    rows.push_back('{mk_req(REQ_FORCE, 32'h7fffffff, 0), 0, '0});
    rows.push_back('{mk_req(REQ_FORCE, 32'h7fffffff, 0), 0, '0});
    rows.push_back('{mk_req(REQ_INTEG, 32'h0, 16'h8000), 0, '0});
    rows.push_back('{mk_req(REQ_SETV, 32'h00010000, 0), 0, '0});
    rows.push_back('{mk_req(REQ_INTEG, 32'h0, 16'h0001), 0, '0});
    rows.push_back('{mk_req(REQ_SETP, 32'h0, 0), 0, '0});
    rows.push_back('{mk_req(REQ_INTEG, 32'h0, 16'h4000), 0, '0});
    foreach (rows[i]) send_item(rows[i].r, rows[i].has_want, rows[i].want);
    drain();

    // zero damping, immovable, one-point-oh damping with strong gravity
    write_reg(CFG_DAMPING, 32'd0);
    write_reg(CFG_INV_MASS, 32'd0);
    write_reg(CFG_ACCEL_X, 32'h80000000);
    write_reg(CFG_ACCEL_Y, 32'h7fffffff);
    write_reg(CFG_ACCEL_Z, 32'hfff63000);
    send_item(mk_req(REQ_SETV, 32'h00123456, 0), 0, '0);
    send_item(mk_req(REQ_FORCE, 32'h7fffffff, 0), 0, '0);
    send_item(mk_req(REQ_INTEG, 32'h0, 16'h2000), 0, '0);
    drain();
    write_reg(CFG_DAMPING, 32'h1ffff);
    write_reg(CFG_INV_MASS, 32'hffffffff);
    send_item(mk_req(REQ_FORCE, 32'h00000003, 0), 0, '0);
    send_item(mk_req(REQ_INTEG, 32'h0, 16'hffff), 0, '0);
    drain();

    // random phases across register settings and idling patterns
    dsets = '{32'd64881, 32'd1, 32'd65536, 32'd40000};
    msets = '{32'd65536, 32'd0, 32'hffffffff, 32'd1000};
    for (int ph = 0; ph < 12; ph++) begin
      case (ph / 4)
        0: begin send_idle_pct = 12; recv_idle_pct = 78; end
        1: begin send_idle_pct = 78; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(CFG_DAMPING, (ph % 5 == 4) ? $urandom_range(65535) : dsets[ph % 4]);
      write_reg(CFG_INV_MASS, (ph % 3 == 2) ? $urandom : msets[(ph + 1) % 4]);
      write_reg(CFG_ACCEL_X, (ph % 2) ? $urandom : 32'd0);
      write_reg(CFG_ACCEL_Y, (ph % 2) ? $urandom_range(1310720) - 655360 : 32'hfff63000);
      write_reg(CFG_ACCEL_Z, (ph == 5) ? 32'h7fffffff : rand_vec());
      for (int k = 0; k < 150; k++) begin
        r = rand_req();
        if (ph == 8 && k == 20) begin
          // long receiver hold while words keep coming
          fork
            begin
              hold_recv = 1'b1;
              for (int c = 0; c < 600; c++) @(posedge clk);
              hold_recv = 1'b0;
            end
          join_none
        end
        if (ph == 9 && k == 40) begin
          // stop offering until every result is back
          item_valid <= 1'b0;
          @(posedge clk);
          while (pending_rsp.size() != 0) @(posedge clk);
        end
        send_item(r, 0, '0);
      end
      drain();
    end

    $display("Covered %0d items (%0d integrates, %0d zero-step) and %0d results",
             n_items, n_integ, n_bad, n_results);
    $display("over several damping, inverse mass and acceleration settings.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Timeout after %0d items", n_items);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
